### src/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared constants and types for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int DEFAULT_COORD_WIDTH = 16;
  localparam int NORM_W              = 16;  // Q1.14 result width
  localparam int ROOT_BITS           = 16;  // bits of floor(32768*|c_i|/|c|)
  localparam int UNIT_SHIFT          = 30;  // 32768^2

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } tfn_side_t;

endpackage

### src/tfn_in_if.sv
// ----------------------------------------------------------------------------
// tfn_in_if
// Input channel: three triangle vertices per transaction.
// ----------------------------------------------------------------------------
interface tfn_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_vertex_x;
  logic signed [COORD_WIDTH-1:0] first_vertex_y;
  logic signed [COORD_WIDTH-1:0] first_vertex_z;
  logic signed [COORD_WIDTH-1:0] second_vertex_x;
  logic signed [COORD_WIDTH-1:0] second_vertex_y;
  logic signed [COORD_WIDTH-1:0] second_vertex_z;
  logic signed [COORD_WIDTH-1:0] third_vertex_x;
  logic signed [COORD_WIDTH-1:0] third_vertex_y;
  logic signed [COORD_WIDTH-1:0] third_vertex_z;

  modport source (
    output valid, first_vertex_x, first_vertex_y, first_vertex_z,
           second_vertex_x, second_vertex_y, second_vertex_z,
           third_vertex_x, third_vertex_y, third_vertex_z,
    input  ready
  );
  modport sink (
    input  valid, first_vertex_x, first_vertex_y, first_vertex_z,
           second_vertex_x, second_vertex_y, second_vertex_z,
           third_vertex_x, third_vertex_y, third_vertex_z,
    output ready
  );
endinterface

### src/tfn_out_if.sv
// ----------------------------------------------------------------------------
// tfn_out_if
// Output channel: unit normal in Q1.14 and degenerate flag per transaction.
// ----------------------------------------------------------------------------
interface tfn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic               degenerate;

  modport source (
    output valid, normal_x, normal_y, normal_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, degenerate,
    output ready
  );
endinterface

### src/tfn_ratio.sv
// ----------------------------------------------------------------------------
// tfn_ratio
// Pipelined square root of a ratio: s = floor(sqrt(t / l)), one bit per stage.
// Keeps r = t - s^2*l and p = s*l so each stage needs only shifts and adds.
// ----------------------------------------------------------------------------
module tfn_ratio import tfn_pkg::*; #(
  parameter int LW = 72,
  parameter int TW = 100
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [TW-1:0]        t,
  input  logic [LW-1:0]        l,
  output logic [ROOT_BITS-1:0] s
);

  localparam int XW = ((LW + 2 * ROOT_BITS + 2) > TW) ? (LW + 2 * ROOT_BITS + 2) : (TW + 1);

  logic [XW-1:0]        r  [ROOT_BITS+1];
  logic [XW-1:0]        p  [ROOT_BITS+1];
  logic [LW-1:0]        lv [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] sv [ROOT_BITS+1];

  assign r[0]  = XW'(t);
  assign p[0]  = '0;
  assign lv[0] = l;
  assign sv[0] = '0;

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
    localparam int B = ROOT_BITS - 1 - k;
    logic [XW-1:0] trial;
    logic          take;

    assign trial = (p[k] << (B + 1)) + (XW'(lv[k]) << (2 * B));
    assign take  = (r[k] >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        r[k+1]  <= take ? (r[k] - trial) : r[k];
        p[k+1]  <= take ? (p[k] + (XW'(lv[k]) << B)) : p[k];
        lv[k+1] <= lv[k];
        sv[k+1] <= take ? (sv[k] | (ROOT_BITS'(1) << B)) : sv[k];
      end
    end
  end

  assign s = sv[ROOT_BITS];

endmodule

### src/triangle_face_normal_top.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_top
// Unit face normal of a triangle, fully pipelined.
//
// in_ch carries the three vertices of one triangle per transaction, out_ch
// returns the unit normal (Q1.14, rounded to nearest, ties away from zero)
// and a degenerate flag, set with a zero normal when the edge cross product
// is zero. A transaction moves on valid and ready both high.
// One triangle is taken every cycle while out_ch is not stalled. Stages from
// accept to out_ch.valid: edges, edge products, cross product, magnitude,
// partial squares, squares, squared length, 16 stages of the bit-serial ratio
// root (one result bit per stage, one per component in parallel), output register.
// The whole pipeline advances together: when out_ch holds a result and the
// receiver is not ready, in_ch.ready drops and every stage holds, so nothing
// is lost or repeated. Bubbles move on whenever the output register is free.
// Reset (rst, synchronous) clears all valid bits; the block is ready on the
// next cycle. There are no configuration registers.
// ----------------------------------------------------------------------------
module triangle_face_normal_top import tfn_pkg::*; #(
  parameter int COORD_WIDTH = DEFAULT_COORD_WIDTH
) (
  input  logic     clk,
  input  logic     rst,
  tfn_in_if.sink   in_ch,
  tfn_out_if.source out_ch
);

  localparam int W  = COORD_WIDTH;
  localparam int EW = W + 1;
  localparam int PW = 2 * EW;
  localparam int CW = PW + 1;
  localparam int HW = EW;
  localparam int AW = 2 * HW;
  localparam int SW = 2 * AW;
  localparam int LW = SW + 2;
  localparam int TW = SW + UNIT_SHIFT;

  logic adv;
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  logic signed [W-1:0] va [3];
  logic signed [W-1:0] vb [3];
  logic signed [W-1:0] vc [3];
  assign va[0] = in_ch.first_vertex_x;
  assign va[1] = in_ch.first_vertex_y;
  assign va[2] = in_ch.first_vertex_z;
  assign vb[0] = in_ch.second_vertex_x;
  assign vb[1] = in_ch.second_vertex_y;
  assign vb[2] = in_ch.second_vertex_z;
  assign vc[0] = in_ch.third_vertex_x;
  assign vc[1] = in_ch.third_vertex_y;
  assign vc[2] = in_ch.third_vertex_z;

  logic [6:0] v;
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [PW-1:0] pr [6];
  logic signed [CW-1:0] cr [3];
  logic [AW-1:0]        mag [3];
  logic [2*HW-1:0]      hh [3];
  logic [2*HW-1:0]      hl [3];
  logic [2*HW-1:0]      ll [3];
  logic [SW-1:0]        sq [3];
  logic [LW-1:0]        lsq;
  logic [TW-1:0]        tq [3];
  tfn_side_t            side4, side5, side6, side7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[5:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= $signed({va[i][W-1], va[i]}) - $signed({vb[i][W-1], vb[i]});
        e2[i] <= $signed({vb[i][W-1], vb[i]}) - $signed({vc[i][W-1], vc[i]});
      end
      pr[0] <= e1[1] * e2[2];
      pr[1] <= e1[2] * e2[1];
      pr[2] <= e1[2] * e2[0];
      pr[3] <= e1[0] * e2[2];
      pr[4] <= e1[0] * e2[1];
      pr[5] <= e1[1] * e2[0];
      for (int i = 0; i < 3; i++) begin
        cr[i] <= $signed({pr[2*i][PW-1], pr[2*i]}) - $signed({pr[2*i+1][PW-1], pr[2*i+1]});
      end
      for (int i = 0; i < 3; i++) begin
        mag[i]       <= cr[i][CW-1] ? AW'(-cr[i]) : AW'(cr[i]);
        side4.neg[i] <= cr[i][CW-1];
      end
      side4.degen <= (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
      for (int i = 0; i < 3; i++) begin
        hh[i] <= mag[i][AW-1:HW] * mag[i][AW-1:HW];
        hl[i] <= mag[i][AW-1:HW] * mag[i][HW-1:0];
        ll[i] <= mag[i][HW-1:0] * mag[i][HW-1:0];
      end
      side5 <= side4;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= (SW'(hh[i]) << (2 * HW)) + (SW'(hl[i]) << (HW + 1)) + SW'(ll[i]);
      end
      side6 <= side5;
      lsq <= LW'(sq[0]) + LW'(sq[1]) + LW'(sq[2]);
      for (int i = 0; i < 3; i++) begin
        tq[i] <= TW'(sq[i]) << UNIT_SHIFT;
      end
      side7 <= side6;
    end
  end

  logic [ROOT_BITS-1:0] root [3];

  for (genvar i = 0; i < 3; i++) begin : g_ratio
    tfn_ratio #(
      .LW (LW),
      .TW (TW)
    ) u_ratio (
      .clk (clk),
      .en  (adv),
      .t   (tq[i]),
      .l   (lsq),
      .s   (root[i])
    );
  end

  logic      rv [ROOT_BITS];
  tfn_side_t rs [ROOT_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ROOT_BITS; k++) begin
        rv[k] <= 1'b0;
      end
    end else if (adv) begin
      rv[0] <= v[6];
      for (int k = 1; k < ROOT_BITS; k++) begin
        rv[k] <= rv[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rs[0] <= side7;
      for (int k = 1; k < ROOT_BITS; k++) begin
        rs[k] <= rs[k-1];
      end
    end
  end

  logic [ROOT_BITS:0] rnd [3];
  logic [NORM_W-1:0]  mg  [3];
  logic [NORM_W-1:0]  nv  [3];
  tfn_side_t          fs;

  assign fs = rs[ROOT_BITS-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = (ROOT_BITS + 1)'(root[i]) + (ROOT_BITS + 1)'(1);
      mg[i]  = NORM_W'(rnd[i] >> 1);
      if (fs.degen) begin
        nv[i] = '0;
      end else if (fs.neg[i]) begin
        nv[i] = -mg[i];
      end else begin
        nv[i] = mg[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= rv[ROOT_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.normal_x   <= nv[0];
      out_ch.normal_y   <= nv[1];
      out_ch.normal_z   <= nv[2];
      out_ch.degenerate <= fs.degen;
    end
  end

endmodule

### bench/tb_triangle_face_normal_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_face_normal_top
// Self-checking bench for the triangle face normal pipeline. Triangles are
// pushed through in_ch, each one predicted with exact integer arithmetic
// (edges, cross product, squared length, rounded Q1.14 ratio), and every
// out_ch transaction is compared against the oldest prediction in order.
// ----------------------------------------------------------------------------
module tb_triangle_face_normal_top import tfn_pkg::*; ();

  localparam int CW = DEFAULT_COORD_WIDTH;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               degen;
  } normal_t;

  typedef logic signed [CW-1:0] coord_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tfn_in_if #(.COORD_WIDTH(CW)) in_ch ();
  tfn_out_if out_ch ();

  triangle_face_normal_top #(.COORD_WIDTH(CW)) DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  normal_t expected_normals[$];
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      mismatches = 0;
  int      results_seen = 0;
  int      degen_seen = 0;
  int      sent = 0;
  int      cycles = 0;

  // exact rounding: largest n with (2n-1)^2 * len2 <= (32768*|c|)^2
  function automatic logic [15:0] unit_component(logic signed [127:0] c,
                                                 logic [191:0] len2);
    logic [127:0] mag;
    logic [191:0] target;
    logic [191:0] lhs;
    int lo, hi, mid;
    mag = c[127] ? -c : c;
    target = ({64'd0, mag} << 15) * ({64'd0, mag} << 15);
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = len2 * 192'((2 * mid - 1) * (2 * mid - 1));
      if (lhs <= target) lo = mid;
      else hi = mid - 1;
    end
    return c[127] ? -16'(lo) : 16'(lo);
  endfunction

  function automatic normal_t face_normal(coord_t v[9]);
    logic signed [127:0] e1[3], e2[3], c[3];
    logic [191:0] len2;
    normal_t r;
    for (int i = 0; i < 3; i++) begin
      e1[i] = 128'(v[i]) - 128'(v[3+i]);
      e2[i] = 128'(v[3+i]) - 128'(v[6+i]);
    end
    c[0] = e1[1] * e2[2] - e1[2] * e2[1];
    c[1] = e1[2] * e2[0] - e1[0] * e2[2];
    c[2] = e1[0] * e2[1] - e1[1] * e2[0];
    len2 = 192'(c[0] * c[0]) + 192'(c[1] * c[1]) + 192'(c[2] * c[2]);
    r = '0;
    if (len2 == 0) begin
      r.degen = 1'b1;
    end else begin
      r.nx = unit_component(c[0], len2);
      r.ny = unit_component(c[1], len2);
      r.nz = unit_component(c[2], len2);
    end
    return r;
  endfunction

  task automatic send_triangle(coord_t v[9]);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.first_vertex_x <= v[0];
    in_ch.first_vertex_y <= v[1];
    in_ch.first_vertex_z <= v[2];
    in_ch.second_vertex_x <= v[3];
    in_ch.second_vertex_y <= v[4];
    in_ch.second_vertex_z <= v[5];
    in_ch.third_vertex_x <= v[6];
    in_ch.third_vertex_y <= v[7];
    in_ch.third_vertex_z <= v[8];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_normals.push_back(face_normal(v));
    sent++;
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    end_burst();
    while (expected_normals.size() != 0) @(posedge clk);
  endtask

  function automatic coord_t rand_coord();
    unique case ($urandom_range(5))
      0: return coord_t'($urandom_range(3) == 0 ? 16'h8000 : 16'h7fff);
      1: return coord_t'($urandom_range(63)) - 32;
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    coord_t v[9];
    coord_t ext[4] = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sh0001};
    v = '{default: 0};
    send_triangle(v);
    v = '{256, 0, 0, 0, 256, 0, 0, 0, 256};
    send_triangle(v);
    v = '{0, 0, 0, 256, 0, 0, 0, 256, 0};
    send_triangle(v);
    v = '{0, 0, 0, 0, 256, 0, 256, 0, 0};
    send_triangle(v);
    v = '{0, 0, 0, 100, 100, 100, 200, 200, 200};
    send_triangle(v);
    v = '{5, 5, 5, 5, 5, 5, 9, -3, 2};
    send_triangle(v);
    v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
          16'sh8000, 16'sh7fff, 16'sh7fff};
    send_triangle(v);
    v = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
          16'sh8000, 16'sh8000, 16'sh7fff};
    send_triangle(v);
    // tie-ish and single-axis cases
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_triangle(v);
    v = '{0, 0, 0, 1, 1, 0, 0, 1, 1};
    send_triangle(v);
    v = '{0, 0, 0, 3, 4, 0, 0, 0, 1};
    send_triangle(v);
    for (int k = 0; k < 10; k++) begin
      for (int i = 0; i < 9; i++) v[i] = ext[$urandom_range(3)];
      send_triangle(v);
    end
    wait_drained();
  endtask

  task automatic test_random(int count);
    coord_t v[9];
    for (int k = 0; k < count; k++) begin
      for (int i = 0; i < 9; i++) v[i] = rand_coord();
      if ($urandom_range(9) == 0) begin
        // collinear: third = second + (second - first) scaled
        for (int i = 0; i < 3; i++) v[6+i] = v[3+i] + (v[3+i] - v[i]) * 2;
        if ($urandom_range(1)) for (int i = 0; i < 3; i++) v[3+i] = v[i];
      end
      send_triangle(v);
    end
    end_burst();
  endtask

  task automatic run_phase(int idle, int stall, int count);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    test_random(count);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        normal_t got, exp;
        got = '{out_ch.normal_x, out_ch.normal_y, out_ch.normal_z, out_ch.degenerate};
        results_seen++;
        if (got.degen) degen_seen++;
        if (expected_normals.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction %p", got);
        end else begin
          exp = expected_normals.pop_front();
          if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d %0d %0d d=%0d, got %0d %0d %0d d=%0d",
                       exp.nx, exp.ny, exp.nz, exp.degen,
                       got.nx, got.ny, got.nz, got.degen);
          end
        end
      end
      out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.first_vertex_x <= '0;
    in_ch.first_vertex_y <= '0;
    in_ch.first_vertex_z <= '0;
    in_ch.second_vertex_x <= '0;
    in_ch.second_vertex_y <= '0;
    in_ch.second_vertex_z <= '0;
    in_ch.third_vertex_x <= '0;
    in_ch.third_vertex_y <= '0;
    in_ch.third_vertex_z <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    run_phase(0, 0, 125);
    run_phase(73, 0, 125);
    wait_drained();
    run_phase(0, 73, 125);
    run_phase(21, 21, 125);
    wait_drained();
    repeat (40) @(posedge clk);
    $display("covered %0d triangles, %0d results, %0d degenerate", sent, results_seen,
             degen_seen);
    $display("idle phases: none, sender 73%%, receiver 73%%, both 21%%");
    if (mismatches == 0 && expected_normals.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d left over", mismatches, expected_normals.size());
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
